// ===== rtl/count_smaller_after_each_core_defines.svh =====
// Assertion macros for the count_smaller_after_each core.
// Used by the top level; expects clk and arst_n in scope.
`ifndef COUNT_SMALLER_AFTER_EACH_CORE_DEFINES_SVH
`define COUNT_SMALLER_AFTER_EACH_CORE_DEFINES_SVH

// Implication checked every clock outside reset.
`define CSA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must hold at every clock outside reset.
`define CSA_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

// ===== rtl/csa_pkg.sv =====
// Package for the count_smaller_after_each core: sizes and FSM state type.
// No dependencies.
package csa_pkg;
	localparam int MAX_N  = 64;
	localparam int ADDR_W = $clog2(MAX_N);
	localparam int CNT_W  = $clog2(MAX_N + 1);
	localparam int VAL_W  = 32;
	localparam int RES_W  = 6;

	typedef enum logic [1:0] {
		S_LOAD,
		S_PIV,
		S_SCAN,
		S_EMIT
	} csa_state_t;
endpackage

// ===== rtl/csa_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module csa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/count_smaller_after_each_core.sv =====
// Count-smaller-after-each core: for each element of a set, the number of later
// elements strictly below it. Loading takes one transfer per cycle; after the
// transfer flagged tlast the set is counted and results go out in arrival order.
// For each result i the core reads the pivot, then compares each later element
// on the single read port of the value memory, then offers the result, which
// the output can stall. No input is taken while results are being produced.
// Up to MAX_N elements are stored; extra ones are dropped and all results of
// that set carry the overflow flag in tuser. Depends on csa_pkg, csa_ram and
// count_smaller_after_each_core_defines.svh.
`include "count_smaller_after_each_core_defines.svh"

module count_smaller_after_each_core import csa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value (signed)
	input  logic        s_tlast,   // last_in
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [5:0] smaller_after, [7:6] zero
	output logic        m_tlast,   // last_out
	output logic        m_tuser    // [0] overflow
);
	csa_state_t state_q, state_d;

	logic [CNT_W-1:0]  cnt_q;    // elements stored in this set
	logic              drop_q;   // an element of this set was dropped
	logic [CNT_W-1:0]  i_q;      // current pivot index
	logic [CNT_W-1:0]  j_q;      // index of the element now on the read data
	logic [VAL_W-1:0]  pivot_q;
	logic [RES_W-1:0]  acc_q;    // running count for the pivot

	logic              in_xfer, out_xfer;
	logic              we;
	logic [ADDR_W-1:0] raddr;
	logic [VAL_W-1:0]  rdata;
	logic [CNT_W-1:0]  i_inc, j_inc;
	logic              res_last;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;
	assign i_inc    = i_q + CNT_W'(1);
	assign j_inc    = j_q + CNT_W'(1);
	assign res_last = (i_inc == cnt_q);
	assign we       = in_xfer && (cnt_q < CNT_W'(MAX_N));

	// Read address for the next cycle's data.
	always_comb begin
		case (state_q)
			S_LOAD:  raddr = '0;
			S_PIV:   raddr = i_inc[ADDR_W-1:0];
			S_SCAN:  raddr = j_inc[ADDR_W-1:0];
			S_EMIT:  raddr = i_inc[ADDR_W-1:0];
			default: raddr = '0;
		endcase
	end

	csa_ram #(.WIDTH(VAL_W), .DEPTH(MAX_N)) u_val_ram (
		.clk   (clk),
		.we    (we),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (s_tdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_LOAD:  if (in_xfer && s_tlast) state_d = S_PIV;
			S_PIV:   state_d = res_last ? S_EMIT : S_SCAN;
			S_SCAN:  if (j_inc == cnt_q) state_d = S_EMIT;
			S_EMIT:  if (out_xfer) state_d = res_last ? S_LOAD : S_PIV;
			default: state_d = S_LOAD;
		endcase
	end

	// Handshake outputs.
	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			S_LOAD:  s_tready = 1'b1;
			S_EMIT:  m_tvalid = 1'b1;
			default: ;
		endcase
	end

	assign m_tdata = {2'b00, acc_q};
	assign m_tlast = res_last;
	assign m_tuser = drop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= '0;
			drop_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_LOAD: begin
					i_q <= '0;
					if (in_xfer) begin
						if (we) cnt_q <= cnt_q + CNT_W'(1);
						else    drop_q <= 1'b1;
					end
				end
				S_PIV:   j_q <= i_inc;
				S_SCAN:  j_q <= j_inc;
				S_EMIT: begin
					if (out_xfer) begin
						if (res_last) begin
							cnt_q  <= '0;
							drop_q <= 1'b0;
						end else begin
							i_q <= i_inc;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			S_PIV: begin
				pivot_q <= rdata;
				acc_q   <= '0;
			end
			S_SCAN: begin
				if ($signed(rdata) < $signed(pivot_q)) acc_q <= acc_q + RES_W'(1);
			end
			default: ;
		endcase
	end

	`CSA_ASSERT_ALWAYS(a_cnt_range, cnt_q <= CNT_W'(MAX_N), "fill count above capacity")
	`CSA_ASSERT_IMP(a_drop_full, drop_q, cnt_q == CNT_W'(MAX_N), "drop flag with room left")
	`CSA_ASSERT_IMP(a_scan_bound, state_q == S_SCAN, (j_q < cnt_q) && (j_q > i_q),
		"scan index outside later elements")
endmodule

// ===== dv/count_smaller_after_each_core_tb.sv =====
// Testbench for count_smaller_after_each_core: random and directed sets of
// signed values, results checked against an in-bench prediction of the counts.
// Depends on csa_pkg and the core RTL.
`timescale 1ns / 100ps

module count_smaller_after_each_core_tb;
	import csa_pkg::*;

	typedef struct packed {
		logic [31:0] value;
		logic        last;
	} elem_t;

	typedef struct packed {
		logic [5:0] smaller;
		logic       last;
		logic       ovf;
	} count_res_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	count_smaller_after_each_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser)
	);

	elem_t      pending_elems[$];
	count_res_t expected_counts[$];
	int         errors;

	// predictor state: signed values of the open set and their running counts
	logic signed [31:0] set_vals[MAX_N];
	int                 set_cnts[MAX_N];
	int                 set_len;
	bit                 set_dropped;

	// sender control
	int  burst_left;
	int  gap_left;
	bit  hold_until_drained;  // pause sender until all results are back
	bit  drain_req;
	bit  in_taken;            // input transfer at the last rising edge
	// receiver control
	int  stall_left;
	int  long_hold;           // cycles of forced receiver hold-off

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Update counts for one accepted transfer; on the closing one, queue results.
	task automatic predict_counts(input elem_t e);
		int i;
		if (set_len < MAX_N) begin
			for (i = 0; i < set_len; i++)
				if (set_vals[i] > $signed(e.value))
					set_cnts[i]++;
			set_vals[set_len] = e.value;
			set_cnts[set_len] = 0;
			set_len++;
		end else begin
			set_dropped = 1'b1;
		end
		if (e.last) begin
			for (i = 0; i < set_len; i++)
				expected_counts.push_back('{set_cnts[i][5:0], i == set_len - 1, set_dropped});
			set_len     = 0;
			set_dropped = 1'b0;
		end
	endtask

	// Driver: bursts with random gaps; optional pause until the core drains.
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && !in_taken) begin
				// keep offering the same transfer
			end else if (hold_until_drained && expected_counts.size() != 0) begin
				s_tvalid <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_elems.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= pending_elems[0].value;
				s_tlast  <= pending_elems[0].last;
				void'(pending_elems.pop_front());
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 12);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
			if (hold_until_drained && expected_counts.size() == 0 && drain_req)
				hold_until_drained = 1'b0;
		end
	end

	// Receiver: own stall pattern, plus a long hold-off when requested.
	always @(negedge clk) begin
		if (arst_n) begin
			if (long_hold > 0) begin
				long_hold--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 7) == 0)
					stall_left = $urandom_range(1, 9);
			end
		end
	end

	// Monitor: prediction on input transfers, checks on output transfers.
	always @(posedge clk) begin
		count_res_t got;
		count_res_t want;
		in_taken = 1'b0;
		if (arst_n) begin
			in_taken = s_tvalid && s_tready;
			if (s_tvalid && s_tready)
				predict_counts('{s_tdata, s_tlast});
			if (m_tvalid && m_tready) begin
				got = '{m_tdata[5:0], m_tlast, m_tuser};
				if (expected_counts.size() == 0) begin
					$display("%0t: unexpected result, actual %p", $realtime, got);
					errors++;
				end else begin
					want = expected_counts.pop_front();
					if (got.smaller !== want.smaller || m_tdata[7:6] !== 2'b00) begin
						$display("%0t: smaller_after mismatch, expected %0d, actual %0d",
							$realtime, want.smaller, m_tdata);
						errors++;
					end
					if (got.last !== want.last) begin
						$display("%0t: last_out mismatch, expected %0b, actual %0b",
							$realtime, want.last, got.last);
						errors++;
					end
					if (got.ovf !== want.ovf) begin
						$display("%0t: overflow mismatch, expected %0b, actual %0b",
							$realtime, want.ovf, got.ovf);
						errors++;
					end
				end
			end
		end
	end

	task automatic add_elem(input logic [31:0] v, input bit last);
		pending_elems.push_back('{v, last});
	endtask

	// Random set of n elements; values drawn narrow (many ties) or full range.
	task automatic add_random_set(input int n);
		int  i;
		bit  narrow;
		logic [31:0] v;
		narrow = $urandom_range(0, 1);
		for (i = 0; i < n; i++) begin
			v = narrow ? 32'($signed($urandom_range(0, 8)) - 4) : $urandom;
			if ($urandom_range(0, 9) == 0)
				v = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
			add_elem(v, i == n - 1);
		end
	endtask

	task automatic wait_drained();
		while (pending_elems.size() != 0 || s_tvalid || expected_counts.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int i;
		int n;
		int fed;
		errors      = 0;
		set_len     = 0;
		set_dropped = 1'b0;
		burst_left  = 0;
		gap_left    = 0;
		stall_left  = 0;
		long_hold   = 0;
		hold_until_drained = 1'b0;
		drain_req   = 1'b0;
		in_taken    = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		m_tready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: single element, extremes, ties, descending, alternating-bit patterns
		add_elem(32'h0000_0000, 1'b1);
		add_elem(32'h7fff_ffff, 1'b0);
		add_elem(32'h8000_0000, 1'b0);
		add_elem(32'hffff_ffff, 1'b0);
		add_elem(32'h0000_0001, 1'b0);
		add_elem(32'h0000_0001, 1'b0);
		add_elem(32'h8000_0000, 1'b1);
		for (i = 0; i < 6; i++)
			add_elem(32'(6 - i), i == 5);
		add_elem(32'haaaa_aaaa, 1'b0);
		add_elem(32'h5555_5555, 1'b1);
		// long receiver hold-off while the directed sets are offered
		long_hold = 400;
		wait_drained();

		// beyond capacity: 64 stored, extras dropped, last one closes the set
		add_random_set(MAX_N + 3);
		wait_drained();
		// exactly full, and full then a lone closing transfer that is dropped
		add_random_set(MAX_N);
		for (i = 0; i < MAX_N; i++)
			add_elem($urandom, 1'b0);
		add_elem(32'h0, 1'b1);
		wait_drained();

		// a few small random sets; sender sometimes pauses until drained
		fed = 0;
		while (fed < 10) begin
			n = $urandom_range(1, 8);
			add_random_set(n);
			fed += n;
			if ($urandom_range(0, 5) == 0) begin
				while (pending_elems.size() != 0 || s_tvalid)
					@(posedge clk);
				drain_req = 1'b1;
				hold_until_drained = 1'b1;
				wait_drained();
				drain_req = 1'b0;
				hold_until_drained = 1'b0;
			end
		end
		wait_drained();
		repeat (200) @(posedge clk);

		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#4000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
